// ===== rtl/mrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfp_pkg
// shared constants, types and the crc helper of the modbus rtu frame parser
// ----------------------------------------------------------------------------
package mrfp_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam int LIM_MIN       = 8;
  localparam int LIM_MAX       = 64;
  localparam int MAX_FRAMES    = 12;
  localparam int DESC_W        = 4;

  localparam logic [7:0] FC_EXC_MASK = 8'h80;
  localparam logic [7:0] FC_RD_HOLD  = 8'h03;
  localparam logic [7:0] FC_RD_INPUT = 8'h04;
  localparam logic [7:0] FC_WR_ONE   = 8'h06;
  localparam logic [7:0] FC_WR_MULTI = 8'h10;
  localparam logic [8:0] LEN_EXC     = 9'd5;
  localparam logic [8:0] LEN_RD_ADD  = 9'd5;
  localparam logic [8:0] LEN_WR      = 9'd8;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  typedef struct packed {
    logic capture;
    logic store;
    logic rd_fc;
    logic lat_fc;
    logic drop_bad;
    logic lat_bc;
    logic crc_rd;
    logic crc_up;
    logic frame_ok;
    logic frame_bad;
    logic emit_start;
    logic emit_rd;
    logic emit_load;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic chunk;
    logic fill_lt2;
    logic short_bc;
    logic exp_bad;
    logic fill_lt_exp;
    logic crc_last;
    logic crc_ok;
    logic have_frames;
    logic emit_last;
  } sts_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== rtl/mrfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrfp_ctrl
// sequencer: store, header decode, crc scan and result emission
// ----------------------------------------------------------------------------
module mrfp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  mrfp_pkg::sts_t sts,
  output mrfp_pkg::cmd_t cmd
);
  import mrfp_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_STORE = 12'b000000000010,
    S_CHK   = 12'b000000000100,
    S_FC    = 12'b000000001000,
    S_BC    = 12'b000000010000,
    S_CRD   = 12'b000000100000,
    S_CUP   = 12'b000001000000,
    S_CEND  = 12'b000010000000,
    S_FIN   = 12'b000100000000,
    S_ERD   = 12'b001000000000,
    S_ELD   = 12'b010000000000,
    S_EWT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EWT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.chunk ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        if (sts.fill_lt2) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_fc = 1'b1;
          state_nxt = S_FC;
        end
      end
      S_FC: begin
        cmd.lat_fc = 1'b1;
        state_nxt  = S_BC;
      end
      S_BC: begin
        priority if (sts.short_bc) begin
          state_nxt = S_FIN;
        end else if (sts.exp_bad) begin
          cmd.drop_bad = 1'b1;
          state_nxt    = S_CHK;
        end else if (sts.fill_lt_exp) begin
          state_nxt = S_FIN;
        end else begin
          cmd.lat_bc = 1'b1;
          state_nxt  = S_CRD;
        end
      end
      S_CRD: begin
        cmd.crc_rd = 1'b1;
        state_nxt  = S_CUP;
      end
      S_CUP: begin
        cmd.crc_up = 1'b1;
        state_nxt  = sts.crc_last ? S_CEND : S_CRD;
      end
      S_CEND: begin
        if (sts.crc_ok) cmd.frame_ok = 1'b1;
        else cmd.frame_bad = 1'b1;
        state_nxt = S_CHK;
      end
      S_FIN: begin
        if (sts.have_frames) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_ERD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_ELD;
      end
      S_ELD: begin
        cmd.emit_load = 1'b1;
        state_nxt     = S_EWT;
      end
      S_EWT: begin
        if (out_tready) begin
          cmd.emit_next = 1'b1;
          state_nxt     = sts.emit_last ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // a result is never offered while a new item could be taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready)) else $error("mrfp_ctrl: in and out both open");
  // every item without chunk_end returns straight to idle after its store
  a_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE && !sts.chunk) |=> in_tready) else $error("mrfp_ctrl: store");
  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("mrfp_ctrl: result lost");

endmodule

// ===== rtl/mrfp_dp.sv =====
// ----------------------------------------------------------------------------
// mrfp_dp
// byte buffer, pointers, crc unit, frame list, counters and result register
// ----------------------------------------------------------------------------
module mrfp_dp #(
  parameter int BUF_DEPTH = mrfp_pkg::BUF_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [6:0]     cfg_wr_data,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  mrfp_pkg::cmd_t cmd,
  output mrfp_pkg::sts_t sts,
  output logic [95:0]    out_tdata,
  output logic           out_tuser,
  output logic           out_tlast
);
  import mrfp_pkg::*;

  localparam int PTR_W   = $clog2(BUF_DEPTH);
  localparam int FILL_W  = $clog2(BUF_DEPTH + 1);
  localparam int LIM_CAP = (BUF_DEPTH < LIM_MAX) ? BUF_DEPTH : LIM_MAX;

  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] s);
    if (s >= (PTR_W+1)'(BUF_DEPTH)) return PTR_W'(s - (PTR_W+1)'(BUF_DEPTH));
    else return PTR_W'(s);
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] c, input logic [9:0] n);
    logic [32:0] s;
    s = {1'b0, c} + 33'(n);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [7:0]        mem [BUF_DEPTH];
  logic [7:0]        rdata_r;
  logic [PTR_W-1:0]  rd_addr;
  logic              rd_en;

  logic [6:0]        cfg_r;
  logic [PTR_W-1:0]  head_r;
  logic [FILL_W-1:0] fill_r;
  logic [31:0]       crc_err_r, drop_r;
  logic [7:0]        byte_r;
  logic              chunk_r;
  logic [7:0]        fc_r, addr_r;
  logic [6:0]        exp_r, idx_r;
  logic [15:0]       crc_r;
  logic              lo_ok_r, hi_ok_r;

  logic [7:0]        d_addr  [MAX_FRAMES];
  logic [7:0]        d_fc    [MAX_FRAMES];
  logic [PTR_W-1:0]  d_start [MAX_FRAMES];
  logic [5:0]        d_len   [MAX_FRAMES];
  logic [DESC_W-1:0] nf_r, d_r;
  logic [5:0]        j_r;

  // effective limit
  logic [6:0] lim;
  always_comb begin
    lim = cfg_r;
    if (lim < 7'(LIM_MIN)) lim = 7'(LIM_MIN);
    if (lim > 7'(LIM_CAP)) lim = 7'(LIM_CAP);
  end

  // store path
  logic [9:0]       fill10, lim10, ndrop;
  logic             full;
  logic [PTR_W-1:0] head_st, wr_addr;
  logic [9:0]       fill_pre;
  always_comb begin
    fill10   = 10'(fill_r);
    lim10    = 10'(lim);
    full     = (fill10 >= lim10);
    ndrop    = full ? (fill10 - lim10 + 10'd1) : 10'd0;
    head_st  = wrap({1'b0, head_r} + (PTR_W+1)'(ndrop));
    fill_pre = full ? (lim10 - 10'd1) : fill10;
    wr_addr  = wrap({1'b0, head_st} + (PTR_W+1)'(fill_pre));
  end

  // header decode
  logic       is_exc, is_rd, is_wr;
  logic [8:0] exp9;
  always_comb begin
    is_exc = |(fc_r & FC_EXC_MASK);
    is_rd  = (fc_r == FC_RD_HOLD) || (fc_r == FC_RD_INPUT);
    is_wr  = (fc_r == FC_WR_ONE) || (fc_r == FC_WR_MULTI);
    priority if (is_exc) exp9 = LEN_EXC;
    else if (is_rd) exp9 = {1'b0, rdata_r} + LEN_RD_ADD;
    else if (is_wr) exp9 = LEN_WR;
    else exp9 = 9'd0;
  end

  logic [5:0] cur_len;
  assign cur_len = d_len[d_r];

  always_comb begin
    sts.chunk       = chunk_r;
    sts.fill_lt2    = (fill10 < 10'd2);
    sts.short_bc    = !is_exc && is_rd && (fill10 < 10'd3);
    sts.exp_bad     = (exp9 == 9'd0) || (10'(exp9) > lim10);
    sts.fill_lt_exp = (fill10 < 10'(exp9));
    sts.crc_last    = (idx_r == exp_r - 7'd1);
    sts.crc_ok      = lo_ok_r && hi_ok_r;
    sts.have_frames = (nf_r != '0);
    sts.emit_last   = (d_r == nf_r - DESC_W'(1)) && (j_r == cur_len - 6'd1);
  end

  // memory read port
  always_comb begin
    rd_en   = cmd.rd_fc | cmd.lat_fc | cmd.crc_rd | cmd.emit_rd;
    rd_addr = wrap({1'b0, d_start[d_r]} + (PTR_W+1)'(j_r));
    priority if (cmd.rd_fc) rd_addr = wrap({1'b0, head_r} + (PTR_W+1)'(1));
    else if (cmd.lat_fc) rd_addr = wrap({1'b0, head_r} + (PTR_W+1)'(2));
    else if (cmd.crc_rd) rd_addr = wrap({1'b0, head_r} + (PTR_W+1)'(idx_r));
    else rd_addr = wrap({1'b0, d_start[d_r]} + (PTR_W+1)'(j_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.store) mem[wr_addr] <= byte_r;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= 7'(LIM_MAX);
      head_r    <= '0;
      fill_r    <= '0;
      crc_err_r <= '0;
      drop_r    <= '0;
      nf_r      <= '0;
      d_r       <= '0;
      j_r       <= '0;
      chunk_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      if (cmd.capture) begin
        chunk_r <= in_last;
        nf_r    <= '0;
      end
      if (cmd.store) begin
        head_r <= head_st;
        fill_r <= FILL_W'(fill_pre + 10'd1);
        drop_r <= sat_add(drop_r, ndrop);
      end
      if (cmd.drop_bad || cmd.frame_bad) begin
        head_r <= wrap({1'b0, head_r} + (PTR_W+1)'(1));
        fill_r <= fill_r - FILL_W'(1);
        drop_r <= sat_add(drop_r, 10'd1);
      end
      if (cmd.frame_bad) crc_err_r <= sat_add(crc_err_r, 10'd1);
      if (cmd.frame_ok) begin
        head_r <= wrap({1'b0, head_r} + (PTR_W+1)'(exp_r));
        fill_r <= fill_r - FILL_W'(exp_r);
        nf_r   <= nf_r + DESC_W'(1);
      end
      if (cmd.emit_start) begin
        d_r <= '0;
        j_r <= '0;
      end
      if (cmd.emit_next) begin
        if (j_r == cur_len - 6'd1) begin
          d_r <= d_r + DESC_W'(1);
          j_r <= '0;
        end else begin
          j_r <= j_r + 6'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) byte_r <= in_byte;
    if (cmd.lat_fc) fc_r <= rdata_r;
    if (cmd.lat_bc) begin
      exp_r <= exp9[6:0];
      idx_r <= '0;
      crc_r <= CRC_INIT;
    end
    if (cmd.crc_up) begin
      if (idx_r + 7'd2 < exp_r) crc_r <= crc16_byte(crc_r, rdata_r);
      if (idx_r == 7'd0) addr_r <= rdata_r;
      if (idx_r == exp_r - 7'd2) lo_ok_r <= (crc_r[7:0] == rdata_r);
      if (idx_r == exp_r - 7'd1) hi_ok_r <= (crc_r[15:8] == rdata_r);
      idx_r <= idx_r + 7'd1;
    end
    if (cmd.frame_ok) begin
      d_addr[nf_r]  <= addr_r;
      d_fc[nf_r]    <= fc_r;
      d_start[nf_r] <= wrap({1'b0, head_r} + (PTR_W+1)'(2));
      d_len[nf_r]   <= 6'(exp_r - 7'd4);
    end
    if (cmd.emit_load) begin
      out_tdata <= {1'b0, drop_r, crc_err_r, (j_r == cur_len - 6'd1), j_r, rdata_r,
                    d_fc[d_r], d_addr[d_r]};
      out_tuser <= |(d_fc[d_r] & FC_EXC_MASK);
      out_tlast <= sts.emit_last;
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    10'(fill_r) <= 10'(BUF_DEPTH)) else $error("mrfp_dp: fill overflow");
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= DESC_W'(MAX_FRAMES)) else $error("mrfp_dp: frame list overflow");
  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (crc_err_r >= $past(crc_err_r) && drop_r >= $past(drop_r)))
    else $error("mrfp_dp: counter went down");

endmodule

// ===== rtl/modbus_rtu_frame_parser.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_frame_parser
// buffers received modbus rtu bytes and emits crc-checked frames byte by byte
// ----------------------------------------------------------------------------
// one item is one received byte; the block takes one item at a time. an item
// without chunk_end is stored at the edge after acceptance and the input opens
// again right after. an item with chunk_end starts a parse over the buffer:
// each attempt runs the header decode states (chk, fc, bc), then, when a full
// frame is there, a crc scan that reads the frame one byte at a time through
// the single buffer read port. a failed attempt drops one byte and retries.
// after parsing, each data byte of every good frame is offered as one result,
// held while out_tready is low; the totals on each result are those after the
// whole parse. no clearing pass after reset is needed.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_parser #(
  parameter int BUF_DEPTH = mrfp_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // max_buffer_len [6:0]
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  // rx_byte [7:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,   // chunk_end
  // slave_addr [7:0], function_code [15:8], data_byte [23:16],
  // data_index [29:24], last_of_frame [30], crc_error_count [62:31],
  // dropped_byte_count [94:63], zero [95]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  output logic        out_tuser,  // is_exception
  output logic        out_tlast   // last_of_run
);
  import mrfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  mrfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // buffer, crc and result datapath
  mrfp_dp #(.BUF_DEPTH(BUF_DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
